// ----- hw/rtl/fnsh_pkg.sv -----
// ----------------------------------------------------------------------------
// fnsh_pkg
// Shared types, constants and the byte folding function of the schema hash.
// ----------------------------------------------------------------------------
package fnsh_pkg;

  localparam int unsigned MAX_NAME_BYTES = 256;
  localparam int unsigned LEN_W          = $clog2(MAX_NAME_BYTES + 1);

  localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [31:0] STR_MULT   = 32'd31;
  localparam logic [1:0]  LAST_ROUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_MIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       mac_mix;
    logic [1:0] mix_idx;
    logic       upd_field;
    logic       upd_schema;
    logic       close_field;
    logic       finish;
  } ctl_t;

  function automatic logic [31:0] fold_byte(input logic [7:0] b);
    logic [7:0] f;
    f = b;
    if (b inside {[8'h41 : 8'h5A]}) begin
      f = b + 8'h20;
    end
    return {{24{f[7]}}, f};
  endfunction

endpackage

// ----- hw/rtl/fnsh_mac.sv -----
// ----------------------------------------------------------------------------
// fnsh_mac
// Shared multiply-add unit: y = a * b + c, modulo 2^32.
// ----------------------------------------------------------------------------
module fnsh_mac (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] y
);

  logic [31:0] prod;

  assign prod = a * b;
  assign y    = prod + c;

endmodule

// ----- hw/rtl/fnsh_ctrl.sv -----
// ----------------------------------------------------------------------------
// fnsh_ctrl
// Sequencer that steps one input beat through byte hashing, four mix rounds
// and the result hand-off.
// ----------------------------------------------------------------------------
module fnsh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          byte_valid,
  input  logic          field_end,
  input  logic          schema_end,
  input  logic          out_valid,
  input  logic          out_ready,
  output fnsh_pkg::ctl_t ctl
);
  import fnsh_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       fe_q;
  logic       se_q;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 2'd0;
      fe_q  <= 1'b0;
      se_q  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) begin
        fe_q <= field_end;
        se_q <= schema_end;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.mix_idx = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (byte_valid) begin
            state_next = S_BYTE;
          end else if (field_end) begin
            state_next = S_MIX;
          end else if (schema_end) begin
            state_next = S_DONE;
          end
        end
      end
      S_BYTE: begin
        ctl.upd_field = 1'b1;
        if (fe_q) begin
          state_next = S_MIX;
        end else if (se_q) begin
          state_next = S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MIX: begin
        ctl.mac_mix    = 1'b1;
        ctl.upd_schema = 1'b1;
        if (cnt == LAST_ROUND) begin
          ctl.close_field = 1'b1;
          cnt_next        = 2'd0;
          state_next      = se_q ? S_DONE : S_IDLE;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = 2'd0;
      end
    endcase
  end

  // The mix round counter only moves inside the mix state.
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_MIX |-> cnt == 2'd0)
    else $error("mix counter nonzero outside mix state");

  // A beat that carries a byte is hashed in the very next cycle.
  a_byte_next: assert property (@(posedge clk) disable iff (rst)
    accept && byte_valid |=> state == S_BYTE)
    else $error("byte beat not hashed next cycle");

  // After the result is handed off the block is ready again.
  a_finish_ready: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> in_ready)
    else $error("not ready after finish");

  // A field close always leads to four mix rounds.
  a_close_mix: assert property (@(posedge clk) disable iff (rst)
    accept && !byte_valid && field_end |=> state == S_MIX && cnt == 2'd0)
    else $error("field close without mix rounds");

endmodule

// ----- hw/rtl/field_name_schema_hash_top.sv -----
// ----------------------------------------------------------------------------
// field_name_schema_hash_top
// Folds a stream of field-name bytes into a 32-bit schema identifier.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  name_byte, byte_valid, field_end,
//                                          schema_end
// out      source     out_valid/out_ready  fingerprint, name_too_long
//
// A beat is accepted in the idle state, then takes a byte step if it carries a
// byte, the mix rounds if it closes a field, a done step if it ends the schema.
// All of this work runs through one shared 32-bit multiply-add unit.
// The result sits in an output register; a schema end waits while it is full.
// Reset sets the schema hash to the FNV offset basis, clears the field hash and drops out_valid.
// ----------------------------------------------------------------------------
module field_name_schema_hash_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         name_byte,
  input  logic               byte_valid,
  input  logic               field_end,
  input  logic               schema_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] fingerprint,
  output logic               name_too_long
);
  import fnsh_pkg::*;

  ctl_t             ctl;
  logic [7:0]       byte_q;
  logic [31:0]      field_hash;
  logic [31:0]      schema_hash;
  logic             any_field_seen;
  logic [LEN_W-1:0] name_length;
  logic             overflow_seen;
  logic [31:0]      mac_a;
  logic [31:0]      mac_b;
  logic [31:0]      mac_c;
  logic [31:0]      mac_y;

  fnsh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_valid (byte_valid),
    .field_end  (field_end),
    .schema_end (schema_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctl        (ctl)
  );

  always_comb begin
    if (ctl.mac_mix) begin
      mac_a = schema_hash ^ {24'd0, field_hash[8*ctl.mix_idx +: 8]};
      mac_b = FNV_PRIME;
      mac_c = 32'd0;
    end else begin
      mac_a = field_hash;
      mac_b = STR_MULT;
      mac_c = fold_byte(byte_q);
    end
  end

  fnsh_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .y (mac_y)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= name_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_hash     <= 32'd0;
      schema_hash    <= FNV_BASIS;
      any_field_seen <= 1'b0;
      name_length    <= '0;
      overflow_seen  <= 1'b0;
    end else if (ctl.finish) begin
      field_hash     <= 32'd0;
      schema_hash    <= FNV_BASIS;
      any_field_seen <= 1'b0;
      name_length    <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      if (ctl.upd_field) begin
        field_hash <= mac_y;
        if (name_length >= LEN_W'(MAX_NAME_BYTES)) begin
          overflow_seen <= 1'b1;
        end else begin
          name_length <= name_length + LEN_W'(1);
        end
      end
      if (ctl.upd_schema) begin
        schema_hash <= mac_y;
      end
      if (ctl.close_field) begin
        field_hash     <= 32'd0;
        name_length    <= '0;
        any_field_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      fingerprint   <= (overflow_seen || !any_field_seen) ? 32'sd0 : $signed(schema_hash);
      name_too_long <= overflow_seen;
    end
  end

endmodule
